FILE: design/lcdct_pkg.sv
// Shared types and constants for the character LCD cursor tracker.
package lcdct_pkg;

    // Event kinds on the input channel; code seven is unused.
    typedef enum logic [2:0] {
        K_WRITE    = 3'd0,
        K_SET      = 3'd1,
        K_SCROLL_L = 3'd2,
        K_SCROLL_R = 3'd3,
        K_CLEAR    = 3'd4,
        K_HOME     = 3'd5,
        K_FLAGS    = 3'd6
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_COLUMN_COUNT  = 2'd0,
        CFG_LINE_COUNT    = 2'd1,
        CFG_TWO_CHIP      = 2'd2,
        CFG_RIGHT_TO_LEFT = 2'd3
    } t_cfg_index;

    localparam int CFG_DATA_W = 6;

    // Controller command bytes.
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DISPLAY  = 8'h08;
    localparam logic [7:0] CMD_SCROLL_L = 8'h18;
    localparam logic [7:0] CMD_SCROLL_R = 8'h1C;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [2:0] FLAGS_RESET = 3'b100;
    localparam logic [2:0] FLAG_CURSOR = 3'b010;

    // Most bytes one event can produce.
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);

    // Packet queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic       chip;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] slot;
        logic [SLOT_W-1:0]         last_idx;
    } t_packet;

endpackage

FILE: design/lcdct_front.sv
// Front end: config registers, cursor state and byte packet assembly per event.
module lcdct_front #(
    parameter int ROW_SPAN = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [1:0]                     i_cfg_index,
    input  logic [lcdct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic [2:0]                     i_kind,
    input  logic [7:0]                     i_char_code,
    input  logic [5:0]                     i_column,
    input  logic [1:0]                     i_row,
    input  logic [2:0]                     i_flag_bits,
    input  logic                           i_full,
    output logic                           o_push,
    output lcdct_pkg::t_packet             o_pkt
);

    localparam int SW = $clog2(ROW_SPAN);

    // configuration
    logic [5:0] r_column_count;
    logic [2:0] r_line_count;
    logic       r_two_chip;
    logic       r_right_to_left;

    // tracked state
    logic [5:0]    r_cur_col, n_cur_col;
    logic [1:0]    r_cur_row, n_cur_row;
    logic [SW-1:0] r_scroll, n_scroll;
    logic          r_pending, n_pending;
    logic          r_active, n_active;
    logic [2:0]    r_flags, n_flags;

    logic [5:0] w_cols;
    logic [2:0] w_lines;
    logic       w_accept;

    // set-cursor unit inputs / outputs
    logic [5:0]    w_sc_col;
    logic [1:0]    w_sc_row;
    logic          w_sc_active;
    logic [SW-1:0] w_sc_scroll;
    logic          w_do_sc;
    logic [1:0]    w_row_cl;
    logic [5:0]    w_base_lo;
    logic [7:0]    w_sum;
    logic [SW-1:0] w_off;
    logic          w_next_chip;
    logic          w_need_off;
    logic [2:0]    w_flags_off;
    logic [SW-1:0] w_mod_tab [256];

    logic          w_act_m;
    logic          w_flag_chg;
    logic          w_is_crlf;
    lcdct_pkg::t_result [4:0] w_slot;
    logic [4:0]    w_sv;
    logic [2:0]    w_cnt;

    // write-char cursor advance
    logic [1:0] w_row_mid;
    logic [6:0] w_x;
    logic [2:0] w_y;

    // (sum mod ROW_SPAN) for every 8-bit sum
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tab[g] = SW'(g % ROW_SPAN);
    end

    assign w_cols  = (r_column_count == 6'd0) ? 6'd1 : r_column_count;
    assign w_lines = (r_line_count == 3'd0) ? 3'd1 :
                     (r_line_count > 3'd4)  ? 3'd4 : r_line_count;

    assign w_accept   = i_in_valid && !i_full;
    assign w_act_m    = r_two_chip & r_active;
    assign w_flag_chg = r_flags[2] ^ i_flag_bits[2];
    assign w_is_crlf  = (i_char_code == lcdct_pkg::CHAR_CR) ||
                        (i_char_code == lcdct_pkg::CHAR_LF);

    // Set-cursor operand selection
    always_comb begin
        w_sc_col    = r_cur_col;
        w_sc_row    = r_cur_row;
        w_sc_active = r_active;
        w_sc_scroll = r_scroll;
        w_do_sc     = 1'b0;
        unique case (i_kind)
            lcdct_pkg::K_WRITE: begin
                w_do_sc = (r_scroll != '0) || r_pending;
            end
            lcdct_pkg::K_SET: begin
                w_sc_col = i_column;
                w_sc_row = i_row;
                w_do_sc  = 1'b1;
            end
            lcdct_pkg::K_CLEAR: begin
                w_sc_col    = 6'd0;
                w_sc_row    = 2'd0;
                w_sc_active = 1'b0;
                w_sc_scroll = '0;
                w_do_sc     = r_two_chip;
            end
            lcdct_pkg::K_HOME: begin
                w_sc_col    = 6'd0;
                w_sc_row    = 2'd0;
                w_sc_scroll = '0;
                w_do_sc     = r_two_chip;
            end
            default: begin
            end
        endcase
    end

    // Address: row offset low bits only on one chip for lines two and three;
    // bit 6 of the offset is always row bit 0.
    assign w_row_cl    = ({1'b0, w_sc_row} >= w_lines) ? 2'(w_lines - 3'd1) : w_sc_row;
    assign w_base_lo   = (!r_two_chip && w_row_cl[1]) ? w_cols : 6'd0;
    assign w_sum       = 8'(w_sc_col) + 8'(w_base_lo) + 8'(w_sc_scroll);
    assign w_off       = w_mod_tab[w_sum];
    assign w_next_chip = r_two_chip & w_row_cl[1];
    assign w_need_off  = w_do_sc && r_two_chip && (w_sc_active != w_next_chip);
    assign w_flags_off = r_flags & ~lcdct_pkg::FLAG_CURSOR;

    // Result slots in emission order: two leading commands, cursor off,
    // set address, data byte.
    always_comb begin
        w_slot = '0;
        w_sv   = '0;
        unique case (i_kind)
            lcdct_pkg::K_SCROLL_L, lcdct_pkg::K_SCROLL_R, lcdct_pkg::K_HOME: begin
                w_slot[0].value = (i_kind == lcdct_pkg::K_SCROLL_L) ? lcdct_pkg::CMD_SCROLL_L :
                                  (i_kind == lcdct_pkg::K_SCROLL_R) ? lcdct_pkg::CMD_SCROLL_R :
                                  lcdct_pkg::CMD_HOME;
                w_slot[1].value = w_slot[0].value;
                w_slot[1].chip  = 1'b1;
                w_sv[0]         = 1'b1;
                w_sv[1]         = r_two_chip;
            end
            lcdct_pkg::K_CLEAR: begin
                // second chip first, then first chip
                w_slot[0].value = lcdct_pkg::CMD_CLEAR;
                w_slot[0].chip  = r_two_chip;
                w_slot[1].value = lcdct_pkg::CMD_CLEAR;
                w_sv[0]         = 1'b1;
                w_sv[1]         = r_two_chip;
            end
            lcdct_pkg::K_FLAGS: begin
                w_slot[0].value = lcdct_pkg::CMD_DISPLAY | {5'd0, i_flag_bits};
                w_slot[1].value = w_slot[0].value;
                w_slot[1].chip  = 1'b1;
                w_sv[0]         = 1'b1;
                if (w_flag_chg && r_two_chip) begin
                    w_sv[1] = 1'b1;
                end else begin
                    w_slot[0].chip = w_act_m;
                end
            end
            default: begin
            end
        endcase

        w_slot[2].value = lcdct_pkg::CMD_DISPLAY | {5'd0, w_flags_off};
        w_slot[2].chip  = w_sc_active;
        w_sv[2]         = w_need_off;

        w_slot[3].value = lcdct_pkg::CMD_SET_ADDR | {1'b0, w_row_cl[0], 6'(w_off)};
        w_slot[3].chip  = w_next_chip;
        w_sv[3]         = w_do_sc;

        w_slot[4].rs    = 1'b1;
        w_slot[4].value = i_char_code;
        w_slot[4].chip  = w_do_sc ? w_next_chip : w_act_m;
        w_sv[4]         = (i_kind == lcdct_pkg::K_WRITE) && !w_is_crlf;
    end

    // Pack valid slots to the front of the packet.
    always_comb begin
        o_pkt = '0;
        w_cnt = 3'd0;
        for (int k = 0; k < 5; k++) begin
            if (w_sv[k]) begin
                o_pkt.slot[w_cnt[lcdct_pkg::SLOT_W-1:0]] = w_slot[k];
                w_cnt = w_cnt + 3'd1;
            end
        end
        o_pkt.last_idx = lcdct_pkg::SLOT_W'(w_cnt - 3'd1);
    end

    assign o_push = w_accept && (w_cnt != 3'd0);

    // Cursor advance for a character write
    assign w_row_mid = w_do_sc ? w_row_cl : r_cur_row;
    assign w_x       = 7'(r_cur_col) + 7'd1;

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_pending = r_pending;
        n_scroll  = r_scroll;
        n_active  = w_do_sc ? w_next_chip : r_active;
        n_flags   = w_need_off ? w_flags_off : r_flags;
        w_y       = {1'b0, w_row_mid};
        unique case (i_kind)
            lcdct_pkg::K_WRITE: begin
                n_pending = 1'b0;
                if (!r_right_to_left) begin
                    if ((i_char_code == lcdct_pkg::CHAR_CR) || (w_x >= {1'b0, w_cols})) begin
                        n_cur_col = 6'd0;
                        w_y       = w_y + 3'd1;
                        n_pending = 1'b1;
                    end else begin
                        n_cur_col = w_x[5:0];
                    end
                end else begin
                    if ((i_char_code == lcdct_pkg::CHAR_LF) || (r_cur_col == 6'd0)) begin
                        n_cur_col = w_cols - 6'd1;
                        w_y       = w_y + 3'd1;
                        n_pending = 1'b1;
                    end else begin
                        n_cur_col = r_cur_col - 6'd1;
                    end
                end
                if (w_y >= w_lines) begin
                    w_y = 3'd0;
                end
                n_cur_row = w_y[1:0];
            end
            lcdct_pkg::K_SET: begin
                n_cur_col = i_column;
                n_cur_row = w_row_cl;
                n_pending = 1'b0;
            end
            lcdct_pkg::K_SCROLL_L: begin
                n_scroll = (r_scroll == SW'(ROW_SPAN - 1)) ? '0 : r_scroll + SW'(1);
            end
            lcdct_pkg::K_SCROLL_R: begin
                n_scroll = (r_scroll == '0) ? SW'(ROW_SPAN - 1) : r_scroll - SW'(1);
            end
            lcdct_pkg::K_CLEAR, lcdct_pkg::K_HOME: begin
                n_cur_col = 6'd0;
                n_cur_row = 2'd0;
                n_pending = 1'b0;
                n_scroll  = '0;
            end
            lcdct_pkg::K_FLAGS: begin
                n_flags = i_flag_bits;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count  <= 6'd20;
            r_line_count    <= 3'd1;
            r_two_chip      <= 1'b0;
            r_right_to_left <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lcdct_pkg::CFG_COLUMN_COUNT:  r_column_count  <= i_cfg_data[5:0];
                lcdct_pkg::CFG_LINE_COUNT:    r_line_count    <= i_cfg_data[2:0];
                lcdct_pkg::CFG_TWO_CHIP:      r_two_chip      <= i_cfg_data[0];
                lcdct_pkg::CFG_RIGHT_TO_LEFT: r_right_to_left <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= 6'd0;
            r_cur_row <= 2'd0;
            r_scroll  <= '0;
            r_pending <= 1'b0;
            r_active  <= 1'b0;
            r_flags   <= lcdct_pkg::FLAGS_RESET;
        end else if (w_accept) begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_scroll  <= n_scroll;
            r_pending <= n_pending;
            r_active  <= n_active;
            r_flags   <= n_flags;
        end
    end

endmodule

FILE: design/lcdct_queue.sv
// Small packet queue between the front end and the byte sequencer.
module lcdct_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcdct_pkg::t_packet i_pkt,
    output logic               o_full,
    input  logic               i_pop,
    output lcdct_pkg::t_packet o_pkt,
    output logic               o_empty
);

    lcdct_pkg::t_packet r_mem [lcdct_pkg::QUEUE_DEPTH];
    logic [lcdct_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [lcdct_pkg::QCNT_W-1:0] r_count;
    logic w_do_push, w_do_pop;

    assign o_full    = (r_count == lcdct_pkg::QCNT_W'(lcdct_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_pkt     = r_mem[r_rd_ptr];

    function automatic logic [lcdct_pkg::QPTR_W-1:0] bump(
        input logic [lcdct_pkg::QPTR_W-1:0] p
    );
        return (p == lcdct_pkg::QPTR_W'(lcdct_pkg::QUEUE_DEPTH - 1)) ?
               '0 : p + lcdct_pkg::QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + lcdct_pkg::QCNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - lcdct_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

FILE: design/lcdct_back.sv
// Byte sequencer: plays one packet out one result per transfer.
module lcdct_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  lcdct_pkg::t_packet i_pkt,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_register_select,
    output logic [7:0]         o_value,
    output logic               o_chip,
    output logic               o_last
);

    lcdct_pkg::t_packet               r_pkt;
    logic [lcdct_pkg::SLOT_W-1:0]     r_idx;
    logic                             r_busy;
    logic                             w_xfer;
    logic                             w_done;
    lcdct_pkg::t_result               w_cur;

    assign w_cur  = r_pkt.slot[r_idx];
    assign o_last = (r_idx == r_pkt.last_idx);
    assign w_xfer = r_busy && !i_out_stall;
    assign w_done = w_xfer && o_last;
    assign o_pop  = !i_empty && (!r_busy || w_done);

    assign o_out_valid       = r_busy;
    assign o_register_select = w_cur.rs;
    assign o_value           = w_cur.value;
    assign o_chip            = w_cur.chip;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkt <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_xfer) begin
            r_idx <= r_idx + lcdct_pkg::SLOT_W'(1);
        end
    end

endmodule

FILE: design/character_lcd_cursor_tracker.sv
// Top level of the character LCD cursor tracker.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | i_in_valid / o_in_stall | i_kind i_char_code i_column i_row i_flag_bits
//  out     | o_out_valid/i_out_stall | o_register_select o_value o_chip o_last
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index i_cfg_data
//
// An event is classified and its cursor state updated in the cycle it is
// accepted; its zero to four bytes pass through the packet queue and leave the
// sequencer at one byte per cycle while i_out_stall is low, a rate set by the
// single output port; single-byte events stream at one per cycle too. Reset
// (synchronous, low) empties the queue and sequencer and restores default
// config and cursor state. An output stall backs up through the two-entry
// packet queue before o_in_stall rises; config is always ready.
module character_lcd_cursor_tracker #(
    parameter int ROW_SPAN = 40
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [lcdct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // events in
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [2:0]                       i_kind,
    input  logic [7:0]                       i_char_code,
    input  logic [5:0]                       i_column,
    input  logic [1:0]                       i_row,
    input  logic [2:0]                       i_flag_bits,
    // controller bytes out
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_register_select,
    output logic [7:0]                       o_value,
    output logic                             o_chip,
    output logic                             o_last
);

    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;
    lcdct_pkg::t_packet w_front_pkt;
    lcdct_pkg::t_packet w_queue_pkt;

    // Config registers sit in the front end and are writable at any cycle.
    assign o_cfg_ready = 1'b1;
    // Front end only stalls when the packet queue is full.
    assign o_in_stall  = w_full;

    lcdct_front #(
        .ROW_SPAN (ROW_SPAN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_flag_bits (i_flag_bits),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_pkt       (w_front_pkt)
    );

    // Each entry holds every byte of one event plus the index of its last byte.
    lcdct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_front_pkt),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_pkt   (w_queue_pkt),
        .o_empty (w_empty)
    );

    // Sequencer reloads on the same edge its final byte transfers when the queue holds a packet: no bubble.
    lcdct_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (w_empty),
        .i_pkt             (w_queue_pkt),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_register_select (o_register_select),
        .o_value           (o_value),
        .o_chip            (o_chip),
        .o_last            (o_last)
    );

endmodule

FILE: design/lcdct_checker.sv
// Port-level assertions for the cursor tracker, bound to the top level.
module lcdct_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [1:0]                       i_cfg_index,
    input logic [lcdct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [2:0]                       i_kind,
    input logic [7:0]                       i_char_code,
    input logic [5:0]                       i_column,
    input logic [1:0]                       i_row,
    input logic [2:0]                       i_flag_bits,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic                             o_register_select,
    input logic [7:0]                       o_value,
    input logic                             o_chip,
    input logic                             o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value) &&
        $stable(o_register_select) && $stable(o_chip) && $stable(o_last))
        else $error("stalled output changed");

    // nothing in flight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // bytes of one event come out without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("gap inside an event's byte burst");

    // line controls never go out as data
    a_no_crlf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_register_select |->
        (o_value != lcdct_pkg::CHAR_CR) && (o_value != lcdct_pkg::CHAR_LF))
        else $error("CR or LF sent as data");

    // commands are one of the known opcodes
    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_register_select |->
        o_value[7] || (o_value == lcdct_pkg::CMD_CLEAR) ||
        (o_value == lcdct_pkg::CMD_HOME) || (o_value[7:3] == 5'b00001) ||
        (o_value == lcdct_pkg::CMD_SCROLL_L) || (o_value == lcdct_pkg::CMD_SCROLL_R))
        else $error("unknown command byte");

endmodule

bind character_lcd_cursor_tracker lcdct_checker u_lcdct_checker (.*);

FILE: bench/tb.sv
// Self-checking testbench for the character LCD cursor tracker.
`timescale 1ns / 1ps

module tb;
    import lcdct_pkg::*;

    localparam int ROW_SPAN      = 40;
    localparam int ROW_HIGH      = 'h40;   // DDRAM address bit of odd rows
    localparam int ADDR_LOW_MASK = 'h3F;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    localparam int MAX_GAP       = 13;
    localparam int HOLD_CYCLES   = 120;    // long output back-pressure stretch
    localparam int DRAIN_CYCLES  = 8;      // idle margin past the last byte
    localparam int WATCHDOG_MAX  = 3000;
    localparam int PHASE_ITEMS   = 44;
    localparam int PHASE_COUNT   = 8;
    localparam int SHOW_MAX      = 10;

    // One controller byte as seen on the output channel.
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic       chip;
        logic       last;
    } lcd_byte_t;

    // One line of the stimulus plan: either an event or a full settings load.
    typedef struct packed {
        logic       is_settings;
        logic [2:0] kind;
        logic [7:0] ch;
        logic [5:0] col;
        logic [1:0] row;
        logic [2:0] flags;
        logic       typed;        // expectation written out in the plan
        logic       typed_rs;
        logic [7:0] typed_value;
        logic [5:0] s_cols;
        logic [5:0] s_lines;
        logic [5:0] s_two;
        logic [5:0] s_rtl;
    } step_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [2:0]            i_kind;
    logic [7:0]            i_char_code;
    logic [5:0]            i_column;
    logic [1:0]            i_row;
    logic [2:0]            i_flag_bits;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_register_select;
    logic [7:0]            o_value;
    logic                  o_chip;
    logic                  o_last;

    character_lcd_cursor_tracker #(
        .ROW_SPAN(ROW_SPAN)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_char_code      (i_char_code),
        .i_column         (i_column),
        .i_row            (i_row),
        .i_flag_bits      (i_flag_bits),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_register_select(o_register_select),
        .o_value          (o_value),
        .o_chip           (o_chip),
        .o_last           (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker mirror: settings and cursor state as the block should hold them
    // ------------------------------------------------------------------
    logic [5:0] cfg_cols  = 6'd20;
    logic [2:0] cfg_lines = 3'd1;
    logic       cfg_two   = 1'b0;
    logic       cfg_rtl   = 1'b0;

    logic [6:0] cur_col   = '0;
    logic [1:0] cur_row   = '0;
    int         scroll    = 0;          // kept in 0..ROW_SPAN-1
    logic       pending   = 1'b0;       // cursor must be re-addressed before data
    logic       act_chip  = 1'b0;
    logic [2:0] dflags    = FLAGS_RESET;

    lcd_byte_t  burst_q[$];             // bytes of the event being worked out
    lcd_byte_t  bytes_due[$];           // bytes the block still owes, oldest first
    step_t      plan[$];

    int   fault_count = 0;
    bit   in_quiet    = 1'b0;
    bit   out_quiet   = 1'b0;
    bit   hold_req    = 1'b0;
    int   idle_cycles = 0;

    function automatic int eff_cols();
        return (cfg_cols == 0) ? 1 : int'(cfg_cols);
    endfunction

    function automatic int eff_lines();
        if (cfg_lines == 0) return 1;
        if (cfg_lines > 4) return 4;
        return int'(cfg_lines);
    endfunction

    // Offset of a display line inside DDRAM; on two chips each chip has
    // only rows 0 and 1.
    function automatic int row_base(input int row);
        if (cfg_two) return (row % 2 != 0) ? ROW_HIGH : 0;
        case (row % 4)
            0: return 0;
            1: return ROW_HIGH;
            2: return eff_cols();
            default: return ROW_HIGH + eff_cols();
        endcase
    endfunction

    function automatic void emit(input logic rs, input logic [7:0] val, input logic chip);
        lcd_byte_t b;
        b.rs    = rs;
        b.value = val;
        b.chip  = cfg_two ? chip : 1'b0;
        b.last  = 1'b0;
        burst_q.push_back(b);
    endfunction

    function automatic void to_both(input logic [7:0] val);
        emit(1'b0, val, 1'b0);
        if (cfg_two) emit(1'b0, val, 1'b1);
    endfunction

    function automatic void go_home();
        scroll  = 0;
        cur_col = '0;
        cur_row = '0;
        pending = 1'b0;
    endfunction

    // Address the cursor; leaving a chip first turns its cursor off.
    function automatic void place_cursor(input int col, input int row);
        int   lines;
        int   base;
        int   off;
        int   addr;
        logic next_chip;
        lines = eff_lines();
        if (row >= lines) row = lines - 1;
        cur_col = col[6:0];
        cur_row = row[1:0];
        pending = 1'b0;
        base = row_base(row);
        off  = (col + (base & ADDR_LOW_MASK) + scroll) % ROW_SPAN;
        next_chip = cfg_two ? row[1] : 1'b0;
        if (cfg_two && act_chip != next_chip) begin
            dflags = dflags & ~FLAG_CURSOR;
            emit(1'b0, CMD_DISPLAY | {5'd0, dflags}, act_chip);
        end
        act_chip = next_chip;
        addr = (off & ADDR_LOW_MASK) | (base & ROW_HIGH);
        emit(1'b0, CMD_SET_ADDR | addr[7:0], act_chip);
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        int cols;
        int x;
        int y;
        cols = eff_cols();
        if (scroll != 0 || pending) place_cursor(int'(cur_col), int'(cur_row));
        if (ch != CHAR_CR && ch != CHAR_LF) emit(1'b1, ch, act_chip);
        pending = 1'b0;
        y = cur_row;
        if (!cfg_rtl) begin
            x = cur_col + 1;
            if (ch == CHAR_CR || x >= cols) begin
                x = 0;
                y++;
                pending = 1'b1;
            end
            cur_col = x[6:0];
        end else begin
            if (ch == CHAR_LF || cur_col == 0) begin
                x = cols - 1;
                cur_col = x[6:0];
                y++;
                pending = 1'b1;
            end else begin
                cur_col = cur_col - 7'd1;
            end
        end
        if (y >= eff_lines()) y = 0;
        cur_row = y[1:0];
    endfunction

    // Works out the controller bytes one accepted event causes into burst_q.
    function automatic void derive_controller_bytes(input step_t s);
        logic changed;
        burst_q.delete();
        case (s.kind)
            K_WRITE: put_char(s.ch);
            K_SET:   place_cursor(int'(s.col), int'(s.row));
            K_SCROLL_L: begin
                to_both(CMD_SCROLL_L);
                scroll = (scroll + 1) % ROW_SPAN;
            end
            K_SCROLL_R: begin
                to_both(CMD_SCROLL_R);
                scroll = (scroll + ROW_SPAN - 1) % ROW_SPAN;
            end
            K_CLEAR: begin
                go_home();
                if (cfg_two) begin
                    // second chip first, then re-home on the first chip
                    emit(1'b0, CMD_CLEAR, 1'b1);
                    emit(1'b0, CMD_CLEAR, 1'b0);
                    act_chip = 1'b0;
                    place_cursor(0, 0);
                end else begin
                    emit(1'b0, CMD_CLEAR, 1'b0);
                end
            end
            K_HOME: begin
                to_both(CMD_HOME);
                go_home();
                if (cfg_two) place_cursor(0, 0);
            end
            K_FLAGS: begin
                changed = (dflags[2] != s.flags[2]);
                dflags  = s.flags;
                if (changed && cfg_two) to_both(CMD_DISPLAY | {5'd0, dflags});
                else emit(1'b0, CMD_DISPLAY | {5'd0, dflags}, act_chip);
            end
            default: ;   // unused kind: no bytes
        endcase
        if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------
    function automatic void add_event(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic [5:0] col, input logic [1:0] row,
                                      input logic [2:0] flags);
        step_t s;
        s = '0;
        s.kind  = kind;
        s.ch    = ch;
        s.col   = col;
        s.row   = row;
        s.flags = flags;
        plan.push_back(s);
    endfunction

    // Event whose single byte is obvious; the byte goes into the plan as written.
    function automatic void add_typed(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic [5:0] col, input logic [1:0] row,
                                      input logic [2:0] flags, input logic rs,
                                      input logic [7:0] value);
        add_event(kind, ch, col, row, flags);
        plan[plan.size() - 1].typed       = 1'b1;
        plan[plan.size() - 1].typed_rs    = rs;
        plan[plan.size() - 1].typed_value = value;
    endfunction

    function automatic void add_settings(input logic [5:0] cols, input logic [5:0] lines,
                                         input logic [5:0] two, input logic [5:0] rtl);
        step_t s;
        s = '0;
        s.is_settings = 1'b1;
        s.s_cols  = cols;
        s.s_lines = lines;
        s.s_two   = two;
        s.s_rtl   = rtl;
        plan.push_back(s);
    endfunction

    // Mostly well-formed traffic: printable text, some line controls, cursor
    // moves inside the row span, and a share of raw values across each field.
    function automatic step_t random_event();
        step_t s;
        int    pick;
        s = '0;
        pick = $urandom_range(0, 99);
        if (pick < 45)      s.kind = K_WRITE;
        else if (pick < 60) s.kind = K_SET;
        else if (pick < 67) s.kind = K_SCROLL_L;
        else if (pick < 74) s.kind = K_SCROLL_R;
        else if (pick < 79) s.kind = K_CLEAR;
        else if (pick < 85) s.kind = K_HOME;
        else if (pick < 95) s.kind = K_FLAGS;
        else                s.kind = KIND_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick == 0)     s.ch = CHAR_CR;
        else if (pick == 1) s.ch = CHAR_LF;
        else if (pick < 5)  s.ch = $urandom_range(0, 255);
        else                s.ch = $urandom_range('h20, 'h7E);
        s.col   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 39);
        s.row   = $urandom_range(0, 3);
        s.flags = $urandom_range(0, 7);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one event after a random gap; valid stays high after the transfer
    // so back-to-back events need no re-raise.
    task automatic send_event(input step_t s);
        int        gap;
        lcd_byte_t b;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= s.kind;
        i_char_code <= s.ch;
        i_column    <= s.col;
        i_row       <= s.row;
        i_flag_bits <= s.flags;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        derive_controller_bytes(s);
        if (s.typed) begin
            b.rs    = s.typed_rs;
            b.value = s.typed_value;
            b.chip  = 1'b0;
            b.last  = 1'b1;
            bytes_due.push_back(b);
        end else begin
            foreach (burst_q[k]) bytes_due.push_back(burst_q[k]);
        end
    endtask

    // Valid is left high between register writes; the caller drops it.
    task automatic write_reg(input t_cfg_index idx, input logic [5:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_COLUMN_COUNT:  cfg_cols  = data;
            CFG_LINE_COUNT:    cfg_lines = data[2:0];
            CFG_TWO_CHIP:      cfg_two   = data[0];
            CFG_RIGHT_TO_LEFT: cfg_rtl   = data[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [5:0] cols, input logic [5:0] lines,
                                 input logic [5:0] two, input logic [5:0] rtl);
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_LINE_COUNT, lines);
        write_reg(CFG_TWO_CHIP, two);
        write_reg(CFG_RIGHT_TO_LEFT, rtl);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering events, wait for every owed byte, then give the block a
    // few cycles in case the last event (e.g. an unused kind) is still in flight.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stall before each byte, plus one long hold-off
    // on request so the packet queue fills and the input stalls.
    initial begin
        int gap;
        i_out_stall <= 1'b1;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Output check: every transfer against the oldest owed byte
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        lcd_byte_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (bytes_due.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_MAX)
                    $display("%0t: unexpected byte rs=%0d value=%02h chip=%0d last=%0d",
                             $realtime, o_register_select, o_value, o_chip, o_last);
            end else begin
                want = bytes_due.pop_front();
                if (o_register_select !== want.rs || o_value !== want.value ||
                    o_chip !== want.chip || o_last !== want.last) begin
                    fault_count++;
                    if (fault_count <= SHOW_MAX)
                        $display({"%0t: byte mismatch, want rs=%0d value=%02h chip=%0d",
                                  " last=%0d, got rs=%0d value=%02h chip=%0d last=%0d"},
                                 $realtime, want.rs, want.value, want.chip, want.last,
                                 o_register_select, o_value, o_chip, o_last);
                end
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int    phase;
        int    done;
        step_t s;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_COLUMN_COUNT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_kind      <= K_WRITE;
        i_char_code <= '0;
        i_column    <= '0;
        i_row       <= '0;
        i_flag_bits <= '0;

        // Directed part, reset settings: 20 columns, one line, one chip.
        add_typed(K_FLAGS, 8'h00, 6'd0, 2'd0, 3'b111, 1'b0, CMD_DISPLAY | 8'h07);
        add_typed(K_WRITE, 8'h41, 6'd0, 2'd0, 3'd0, 1'b1, 8'h41);
        add_typed(K_WRITE, 8'hFF, 6'd0, 2'd0, 3'd0, 1'b1, 8'hFF);
        add_typed(K_WRITE, 8'h00, 6'd0, 2'd0, 3'd0, 1'b1, 8'h00);
        // row past the line count is clamped to row 0; column 39 -> 0x27
        add_typed(K_SET, 8'h00, 6'd39, 2'd3, 3'd0, 1'b0, CMD_SET_ADDR | 8'h27);
        add_event(K_WRITE, CHAR_CR, 6'd0, 2'd0, 3'd0);      // line control, no data
        add_event(K_WRITE, 8'h5A, 6'd0, 2'd0, 3'd0);        // re-address then data
        add_typed(K_SCROLL_L, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0, CMD_SCROLL_L);
        add_typed(K_SCROLL_R, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0, CMD_SCROLL_R);
        add_typed(K_SCROLL_R, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0, CMD_SCROLL_R); // wraps to 39
        add_event(K_WRITE, CHAR_LF, 6'd0, 2'd0, 3'd0);      // scrolled: re-address
        add_event(KIND_UNUSED, 8'hFF, 6'd63, 2'd3, 3'b111); // dropped silently
        add_typed(K_CLEAR, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0, CMD_CLEAR);
        add_typed(K_HOME, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0, CMD_HOME);
        add_typed(K_FLAGS, 8'h00, 6'd0, 2'd0, 3'b000, 1'b0, CMD_DISPLAY);
        // zero column and line counts behave as one
        add_settings(6'd0, 6'd0, 6'd0, 6'd0);
        add_event(K_WRITE, 8'h31, 6'd0, 2'd0, 3'd0);
        add_event(K_WRITE, 8'h32, 6'd0, 2'd0, 3'd0);
        // widest rows, line count above four, two chips, right to left
        add_settings(6'd40, 6'd7, 6'd1, 6'd1);
        add_event(K_SET, 8'h00, 6'd5, 2'd3, 3'd0);          // switch chip: cursor off
        add_event(K_WRITE, CHAR_LF, 6'd0, 2'd0, 3'd0);
        add_event(K_WRITE, 8'h41, 6'd0, 2'd0, 3'd0);
        add_event(K_FLAGS, 8'h00, 6'd0, 2'd0, 3'b100);      // display-on change: both chips
        add_event(K_FLAGS, 8'h00, 6'd0, 2'd0, 3'b011);
        add_event(K_CLEAR, 8'h00, 6'd0, 2'd0, 3'd0);
        add_event(K_HOME, 8'h00, 6'd0, 2'd0, 3'd0);
        add_event(K_SET, 8'h00, 6'd63, 2'd2, 3'd0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_settings) begin
                settle();
                load_settings(plan[k].s_cols, plan[k].s_lines, plan[k].s_two, plan[k].s_rtl);
            end else begin
                send_event(plan[k]);
            end
        end

        // Random part: one settings load per phase, extremes first.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                0: load_settings(6'd1, 6'd1, 6'd0, 6'd0);
                1: load_settings(6'd40, 6'd4, 6'd1, 6'd1);
                2: load_settings(6'd63, 6'd7, 6'd1, 6'd0);
                3: load_settings(6'd0, 6'd0, 6'd0, 6'd1);
                default: load_settings($urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 63), $urandom_range(0, 63));
            endcase
            in_quiet  = (phase == 1 || phase == 2 || phase == 6);
            out_quiet = (phase == 2 || phase == 5);
            // phase 1: sender runs flat out while the receiver holds off
            if (phase == 1) hold_req = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                s = random_event();
                send_event(s);
                if (s.kind != KIND_UNUSED) done++;
            end
        end

        settle();
        fault_count += bytes_due.size();
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
